>>> design/adb_command_pulse_decoder_assert.svh
// Assertion macros shared by the checker of the command pulse decoder.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ADB_COMMAND_PULSE_DECODER_ASSERT_SVH
`define ADB_COMMAND_PULSE_DECODER_ASSERT_SVH

// Same-cycle implication, masked while reset is active.
`define ACPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is active.
`define ACPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that is also checked while reset is active.
`define ACPD_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/acpd_pkg.sv
package acpd_pkg;

  // Decoder phase within one command.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SYNC  = 2'd1,
    PH_BITLO = 2'd2,
    PH_BITHI = 2'd3
  } phase_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_ATTN  = 3'd1,
    ST_RESET = 3'd2,
    ST_SYNC  = 3'd3,
    ST_BIT   = 3'd4
  } status_e;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTN_MIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT_SYNC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT_DUTY = 2'd2;

  localparam logic [10:0] ATTN_MIN_RESET = 11'd500;

  // Timing limits in microseconds.
  localparam logic [15:0] ATTN_MAX_US     = 16'd1040;
  localparam logic [15:0] GRST_MIN_US     = 16'd2800;
  localparam logic [15:0] ATTN_TIMEOUT_US = 16'd4000;
  localparam logic [15:0] SYNC_TIMEOUT_US = 16'd150;
  localparam logic [15:0] SYNC_LO_US      = 16'd40;
  localparam logic [15:0] SYNC_HI_US      = 16'd95;
  localparam logic [15:0] SYNC_LO_STR_US  = 16'd42;
  localparam logic [15:0] SYNC_HI_STR_US  = 16'd91;
  localparam logic [15:0] BIT_LOW_MAX_US  = 16'd130;
  localparam logic [15:0] BIT_HIGH_MAX_US = 16'd100;
  localparam logic [8:0]  CELL_MIN_US     = 9'd70;
  localparam logic [8:0]  CELL_MAX_US     = 9'd130;
  localparam logic [3:0]  BITS_PER_CMD    = 4'd8;

  // Duty-cycle weights in percent.
  localparam logic [15:0] DUTY_SCALE = 16'd100;
  localparam logic [15:0] DUTY_ONE   = 16'd35;
  localparam logic [15:0] DUTY_MID   = 16'd50;
  localparam logic [15:0] DUTY_ZERO  = 16'd65;

  typedef struct packed {
    logic [10:0] attn_min_us;
    logic        strict_sync;
    logic        strict_duty;
  } cfg_t;

  typedef struct packed {
    logic        level;
    logic [15:0] duration_us;
    logic        want_srq;
  } item_t;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_byte;
    logic [7:0]  low_length;
  } ctx_t;

  typedef struct packed {
    logic        emit;
    status_e     status;
    logic [7:0]  command;
    logic        assert_srq;
  } result_t;

endpackage

>>> design/acpd_decode.sv
// Combinational decode of one measured phase against the current context.
module acpd_decode (
  input  acpd_pkg::cfg_t    cfg_i,
  input  acpd_pkg::ctx_t    ctx_i,
  input  acpd_pkg::item_t   item_i,
  output acpd_pkg::ctx_t    ctx_o,
  output acpd_pkg::result_t res_o
);
  import acpd_pkg::*;

  logic [15:0] dur;
  logic [15:0] attn_dur;
  logic        attn_bad;
  logic [15:0] sync_lo;
  logic [15:0] sync_hi;
  logic [8:0]  cell_us;
  logic [15:0] lo100;
  logic [15:0] cell_one;
  logic [15:0] cell_mid;
  logic [15:0] cell_zero;
  logic        bit_val;
  logic        duty_bad;
  logic [3:0]  count_inc;
  logic [7:0]  shift_inc;

  // Window checks and duty-cycle arithmetic.
  always_comb begin
    dur       = item_i.duration_us;
    attn_dur  = (dur > ATTN_TIMEOUT_US) ? 16'd0 : dur;
    attn_bad  = (attn_dur == 16'd0) || (attn_dur > ATTN_MAX_US) ||
                (attn_dur < {5'd0, cfg_i.attn_min_us});
    sync_lo   = cfg_i.strict_sync ? SYNC_LO_STR_US : SYNC_LO_US;
    sync_hi   = cfg_i.strict_sync ? SYNC_HI_STR_US : SYNC_HI_US;
    cell_us   = {1'b0, ctx_i.low_length} + {1'b0, dur[7:0]};
    lo100     = {8'd0, ctx_i.low_length} * DUTY_SCALE;
    cell_one  = {7'd0, cell_us} * DUTY_ONE;
    cell_mid  = {7'd0, cell_us} * DUTY_MID;
    cell_zero = {7'd0, cell_us} * DUTY_ZERO;
    if (cfg_i.strict_duty) begin
      bit_val  = (lo100 < cell_one);
      duty_bad = !(lo100 < cell_one) && !(lo100 > cell_zero);
    end else begin
      bit_val  = (lo100 < cell_mid);
      duty_bad = 1'b0;
    end
    count_inc = ctx_i.bit_count + 4'd1;
    shift_inc = {ctx_i.shift_byte[6:0], bit_val};
  end

  // Phase sequencing and result selection.
  always_comb begin
    ctx_o            = ctx_i;
    res_o.emit       = 1'b0;
    res_o.status     = ST_OK;
    res_o.command    = 8'd0;
    res_o.assert_srq = 1'b0;
    unique case (ctx_i.phase)
      PH_IDLE: begin
        if (!item_i.level) begin
          if (attn_bad) begin
            res_o.emit   = 1'b1;
            res_o.status = (attn_dur >= GRST_MIN_US) ? ST_RESET : ST_ATTN;
          end else begin
            ctx_o.phase = PH_SYNC;
          end
        end
      end
      PH_SYNC: begin
        if (!item_i.level) begin
          ctx_o.phase = PH_IDLE;
        end else if ((dur == 16'd0) || (dur > SYNC_TIMEOUT_US) ||
                     (dur > sync_hi) || (dur < sync_lo)) begin
          res_o.emit   = 1'b1;
          res_o.status = ST_SYNC;
          ctx_o.phase  = PH_IDLE;
        end else begin
          ctx_o.bit_count  = 4'd0;
          ctx_o.shift_byte = 8'd0;
          ctx_o.phase      = PH_BITLO;
        end
      end
      PH_BITLO: begin
        if (item_i.level) begin
          ctx_o.phase = PH_IDLE;
        end else if ((dur == 16'd0) || (dur > BIT_LOW_MAX_US)) begin
          res_o.emit   = 1'b1;
          res_o.status = ST_BIT;
          ctx_o.phase  = PH_IDLE;
        end else begin
          ctx_o.low_length = dur[7:0];
          ctx_o.phase      = PH_BITHI;
        end
      end
      PH_BITHI: begin
        if (!item_i.level) begin
          ctx_o.phase = PH_IDLE;
        end else if ((dur == 16'd0) || (dur > BIT_HIGH_MAX_US) ||
                     (cell_us < CELL_MIN_US) || (cell_us > CELL_MAX_US) || duty_bad) begin
          res_o.emit   = 1'b1;
          res_o.status = ST_BIT;
          ctx_o.phase  = PH_IDLE;
        end else begin
          ctx_o.shift_byte = shift_inc;
          ctx_o.bit_count  = count_inc;
          if (count_inc >= BITS_PER_CMD) begin
            res_o.emit       = 1'b1;
            res_o.status     = ST_OK;
            res_o.command    = shift_inc;
            res_o.assert_srq = item_i.want_srq;
            ctx_o.phase      = PH_IDLE;
          end else begin
            ctx_o.phase = PH_BITLO;
          end
        end
      end
    endcase
  end

endmodule

>>> design/adb_command_pulse_decoder.sv
// Channel   Dir  Handshake                    Payload (lowest bit first)
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: level; tdata: duration_us, want_srq
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: status, command, assert_srq
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// A result is offered on m_axis after its item is accepted: the item is held in
// the input register until the decode loads the result register. One item per
// cycle is sustained unless a stall on m_axis holds it; the decode state updates
// as an item leaves the input register. Items that cause no result leave no output.
// Reset (rst_ni low, asynchronous) returns to idle and loads register defaults.
// A stalled result holds; the input register keeps taking items until it is full.
module adb_command_pulse_decoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [acpd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [acpd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [23:0]                        s_axis_tdata,  // duration_us, want_srq, zero pad
  input  logic                               s_axis_tuser,  // level
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [15:0]                        m_axis_tdata   // status, command, assert_srq, pad
);
  import acpd_pkg::*;

  cfg_t    cfg_q;
  logic    in_valid_q;
  logic    in_valid_d;
  item_t   in_item_q;
  ctx_t    ctx_q;
  ctx_t    ctx_d;
  result_t res;
  logic    out_valid_q;
  logic    out_valid_d;
  status_e out_status_q;
  logic [7:0] out_cmd_q;
  logic    out_srq_q;
  logic    advance;
  logic    in_take;

  // Flow control between the input and result registers.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_take || (in_valid_q && !advance);
  assign out_valid_d   = advance ? res.emit : (out_valid_q && !m_axis_tready);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attn_min_us <= ATTN_MIN_RESET;
      cfg_q.strict_sync <= 1'b0;
      cfg_q.strict_duty <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ATTN_MIN:    cfg_q.attn_min_us <= cfg_wdata_i;
        CFG_STRICT_SYNC: cfg_q.strict_sync <= cfg_wdata_i[0];
        CFG_STRICT_DUTY: cfg_q.strict_duty <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.level       <= s_axis_tuser;
      in_item_q.duration_us <= s_axis_tdata[15:0];
      in_item_q.want_srq    <= s_axis_tdata[16];
    end
  end

  // Phase decode.
  acpd_decode u_decode (
    .cfg_i  (cfg_q),
    .ctx_i  (ctx_q),
    .item_i (in_item_q),
    .ctx_o  (ctx_d),
    .res_o  (res)
  );

  // Decoder context.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.phase      <= PH_IDLE;
      ctx_q.bit_count  <= 4'd0;
      ctx_q.shift_byte <= 8'd0;
      ctx_q.low_length <= 8'd0;
    end else if (advance) begin
      ctx_q <= ctx_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) begin
      out_status_q <= res.status;
      out_cmd_q    <= res.command;
      out_srq_q    <= res.assert_srq;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_srq_q, out_cmd_q, out_status_q};

endmodule

>>> design/acpd_checker.sv
`include "adb_command_pulse_decoder_assert.svh"

// Port-level checks on the command pulse decoder.
module acpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import acpd_pkg::*;

  logic [2:0] out_status;
  logic [7:0] out_cmd;
  logic       out_srq;
  logic       out_stall;
  logic       out_err;

  // Result fields as packed on the output stream.
  assign out_status = m_axis_tdata[2:0];
  assign out_cmd    = m_axis_tdata[10:3];
  assign out_srq    = m_axis_tdata[11];
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_err    = m_axis_tvalid && (out_status != ST_OK);

  // No result is offered while reset is held.
  `ACPD_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni, !m_axis_tvalid, "result valid during reset")

  // A stalled result keeps its item.
  `ACPD_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "result changed")

  // Status codes stay within the defined set.
  `ACPD_ASSERT_IMP(a_status_range, m_axis_tvalid, out_status <= ST_BIT, "undefined status code")

  // Error results carry no command byte and no service request.
  `ACPD_ASSERT_IMP(a_error_clean, out_err, (out_cmd == 8'd0) && !out_srq, "error has payload")

endmodule

bind adb_command_pulse_decoder acpd_checker u_acpd_checker (.*);
